### hw/rtl/fair_reader_writer_lock_manager_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the reader-writer lock manager
// Each macro expects signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef FAIR_READER_WRITER_LOCK_MANAGER_UNIT_DEFINES_SVH
`define FAIR_READER_WRITER_LOCK_MANAGER_UNIT_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define FRWL_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define FRWL_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hw/rtl/frwl_pkg.sv
// ----------------------------------------------------------------------------
// frwl_pkg
// Shared types, codes and default sizes of the reader-writer lock manager.
// ----------------------------------------------------------------------------
package frwl_pkg;

    // Field widths of a request and of a result.
    localparam int MODE_W   = 3;
    localparam int ID_W     = 8;
    localparam int STATUS_W = 3;

    // Default sizes, handed to the top level parameters.
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_MAX_READERS = 255;

    // Most grants a single handoff may produce.
    localparam int RESULT_CAP = 16;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_TRY_EXCL  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TRY_SHRD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WAIT_EXCL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WAIT_SHRD = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REL_EXCL  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REL_SHRD  = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISUSE   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

    // Classified operations passed from the front end to the back end.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_ACQ_EXCL = 3'd0;
    localparam logic [OP_W-1:0] OP_ACQ_SHRD = 3'd1;
    localparam logic [OP_W-1:0] OP_REL_EXCL = 3'd2;
    localparam logic [OP_W-1:0] OP_REL_SHRD = 3'd3;
    localparam logic [OP_W-1:0] OP_BAD      = 3'd4;

    // One classified command.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            blocking;
        logic [ID_W-1:0] id;
    } frwl_cmd_t;

    // Lock status seen by the top level.
    typedef struct packed {
        logic held_excl;
        logic readers_zero;
        logic queue_empty;
        logic idle;
    } frwl_stat_t;

endpackage

### hw/rtl/frwl_front.sv
// ----------------------------------------------------------------------------
// frwl_front
// Accepts requests, classifies the mode and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module frwl_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [frwl_pkg::MODE_W-1:0] mode,
    input  logic [frwl_pkg::ID_W-1:0]   requester_id,
    output logic                        cmd_valid,
    input  logic                        cmd_pop,
    output frwl_pkg::frwl_cmd_t         cmd
);
    import frwl_pkg::*;

    frwl_cmd_t   slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        push;
    frwl_cmd_t   decoded;

    // Classify the incoming mode.
    always_comb
    begin
        decoded.id       = requester_id;
        decoded.blocking = 1'b0;
        unique case (mode) inside
            MODE_TRY_EXCL:
            begin
                decoded.op = OP_ACQ_EXCL;
            end
            MODE_WAIT_EXCL:
            begin
                decoded.op       = OP_ACQ_EXCL;
                decoded.blocking = 1'b1;
            end
            MODE_TRY_SHRD:
            begin
                decoded.op = OP_ACQ_SHRD;
            end
            MODE_WAIT_SHRD:
            begin
                decoded.op       = OP_ACQ_SHRD;
                decoded.blocking = 1'b1;
            end
            MODE_REL_EXCL:
            begin
                decoded.op = OP_REL_EXCL;
            end
            MODE_REL_SHRD:
            begin
                decoded.op = OP_REL_SHRD;
            end
            default:
            begin
                decoded.op = OP_BAD;
            end
        endcase
    end

    // Queue control: stall only when both entries are occupied.
    assign req_stall = (cnt_reg == 2'd2);
    assign push      = req_valid && !req_stall;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

### hw/rtl/frwl_back.sv
// ----------------------------------------------------------------------------
// frwl_back
// Executes classified commands against the lock state and the waiter queue,
// and drives the result register.
// ----------------------------------------------------------------------------
module frwl_back #(
    parameter int QUEUE_DEPTH = frwl_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_READERS = frwl_pkg::DEF_MAX_READERS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_pop,
    input  frwl_pkg::frwl_cmd_t           cmd,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [frwl_pkg::STATUS_W-1:0] status,
    output logic [frwl_pkg::ID_W-1:0]     grantee_id,
    output logic                          grant_is_shared,
    output logic                          last,
    output frwl_pkg::frwl_stat_t          stat
);
    import frwl_pkg::*;

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int RC_W      = $clog2(MAX_READERS + 1);
    localparam int GRANT_CAP = (RESULT_CAP < MAX_READERS) ? RESULT_CAP : MAX_READERS;
    localparam int N_W       = $clog2(GRANT_CAP + 1);
    localparam int ENTRY_W   = ID_W + 1;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [RC_W-1:0]  RC_MAX   = RC_W'(MAX_READERS);
    localparam logic [N_W-1:0]   N_CAP    = N_W'(GRANT_CAP);

    // Back end states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_GRANT = 2'd2;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        next_ptr = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    logic [ENTRY_W-1:0] wait_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rd0_reg;
    logic [ENTRY_W-1:0] rd1_reg;
    logic [ENTRY_W-1:0] wr_entry;
    logic               mem_we;

    logic [1:0]       state_reg, state_next;
    logic             held_reg, held_next;
    logic [RC_W-1:0]  rc_reg, rc_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [N_W-1:0]   n_reg, n_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [ID_W-1:0]     grantee_reg;
    logic                shared_reg;
    logic                last_reg;

    logic                load;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_id;
    logic                o_shared;
    logic                o_last;
    logic                out_free;
    logic                excl_ok;
    logic                shared_ok;
    logic [N_W-1:0]      n_inc;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign excl_ok   = !held_reg && (rc_reg == '0);
    assign shared_ok = !held_reg && (rc_reg < RC_MAX) && ((rc_reg == '0) || (cnt_reg == '0));
    assign n_inc     = n_reg + N_W'(1);

    // Command execution and handoff sequencing.
    always_comb
    begin
        state_next = state_reg;
        held_next  = held_reg;
        rc_next    = rc_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        mem_we     = 1'b0;
        wr_entry   = {cmd.op == OP_ACQ_SHRD, cmd.id};
        cmd_pop    = 1'b0;
        load       = 1'b0;
        o_status   = ST_MISUSE;
        o_id       = cmd.id;
        o_shared   = 1'b0;
        o_last     = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    load    = 1'b1;
                    unique case (cmd.op) inside
                        OP_ACQ_EXCL, OP_ACQ_SHRD:
                        begin
                            if ((cmd.op == OP_ACQ_EXCL) ? excl_ok : shared_ok)
                            begin
                                o_status = ST_GRANTED;
                                if (cmd.op == OP_ACQ_SHRD)
                                begin
                                    o_shared = 1'b1;
                                    rc_next  = rc_reg + RC_W'(1);
                                end
                                else
                                begin
                                    held_next = 1'b1;
                                end
                            end
                            else if (!cmd.blocking)
                            begin
                                o_status = ST_REFUSED;
                            end
                            else if (cnt_reg == CNT_FULL)
                            begin
                                o_status = ST_FULL;
                            end
                            else
                            begin
                                o_status  = ST_QUEUED;
                                mem_we    = 1'b1;
                                tail_next = next_ptr(tail_reg);
                                cnt_next  = cnt_reg + CNT_W'(1);
                            end
                        end
                        OP_REL_EXCL:
                        begin
                            if (held_reg)
                            begin
                                held_next = 1'b0;
                                if (cnt_reg == '0)
                                begin
                                    o_status = ST_RELEASED;
                                end
                                else
                                begin
                                    load       = 1'b0;
                                    n_next     = '0;
                                    state_next = S_READ;
                                end
                            end
                        end
                        OP_REL_SHRD:
                        begin
                            if (!held_reg && (rc_reg != '0))
                            begin
                                rc_next = rc_reg - RC_W'(1);
                                if ((rc_reg != RC_W'(1)) || (cnt_reg == '0))
                                begin
                                    o_status = ST_RELEASED;
                                end
                                else
                                begin
                                    load       = 1'b0;
                                    n_next     = '0;
                                    state_next = S_READ;
                                end
                            end
                        end
                        default:
                        begin
                            o_status = ST_MISUSE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // Head and next entry are read this cycle.
                state_next = S_GRANT;
            end
            S_GRANT:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    o_status  = ST_GRANTED;
                    o_id      = rd0_reg[ID_W-1:0];
                    head_next = next_ptr(head_reg);
                    cnt_next  = cnt_reg - CNT_W'(1);
                    if (!rd0_reg[ID_W])
                    begin
                        held_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        o_shared   = 1'b1;
                        rc_next    = rc_reg + RC_W'(1);
                        n_next     = n_inc;
                        // The run ends at an empty queue, at the cap or at a writer.
                        o_last     = (cnt_reg == CNT_W'(1)) || (n_inc == N_CAP) ||
                                     !rd1_reg[ID_W];
                        state_next = o_last ? S_IDLE : S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Waiter memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wait_mem[tail_reg] <= wr_entry;
        end
        rd0_reg <= wait_mem[head_reg];
        rd1_reg <= wait_mem[next_ptr(head_reg)];
    end

    // Lock and queue state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= 1'b0;
            rc_reg        <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            n_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            rc_reg        <= rc_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result register: holds while the receiver stalls.
    assign rsp_valid_next = load || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg  <= o_status;
            grantee_reg <= o_id;
            shared_reg  <= o_shared;
            last_reg    <= o_last;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign status          = status_reg;
    assign grantee_id      = grantee_reg;
    assign grant_is_shared = shared_reg;
    assign last            = last_reg;

    assign stat.held_excl    = held_reg;
    assign stat.readers_zero = (rc_reg == '0);
    assign stat.queue_empty  = (cnt_reg == '0);
    assign stat.idle         = (state_reg == S_IDLE);

endmodule

### hw/rtl/fair_reader_writer_lock_manager_unit.sv
// ----------------------------------------------------------------------------
// fair_reader_writer_lock_manager_unit
// Fair reader-writer lock manager with a queue of waiting requesters.
// ----------------------------------------------------------------------------
// Usage:
// A request transaction (mode, requester_id) is taken on the req channel when
// req_valid is high and req_stall is low. Each request yields one or more
// result transactions on the rsp channel, the final one marked by last.
// Requests are classified and held in a two-entry queue, so the requester is
// stalled only when that queue is full.
// A request with a single result passes the front end queue and the result
// register before it appears on rsp; such requests sustain one per cycle
// while rsp is not stalled and no handoff is under way. For each waiter that a
// release resumes, S_READ reads the head of the waiter memory and then S_GRANT
// loads the grant into the result register.
// When the receiver holds rsp_stall, the result is held and the back end
// waits; the front end keeps accepting until its queue is full.
// Reset clears the lock, the reader count and the waiter queue pointers at
// once; no clearing pass is needed and the block accepts work immediately.
// ----------------------------------------------------------------------------
`include "fair_reader_writer_lock_manager_unit_defines.svh"

module fair_reader_writer_lock_manager_unit #(
    parameter int QUEUE_DEPTH = frwl_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_READERS = frwl_pkg::DEF_MAX_READERS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [frwl_pkg::MODE_W-1:0]   mode,
    input  logic [frwl_pkg::ID_W-1:0]     requester_id,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [frwl_pkg::STATUS_W-1:0] status,
    output logic [frwl_pkg::ID_W-1:0]     grantee_id,
    output logic                          grant_is_shared,
    output logic                          last
);
    import frwl_pkg::*;

    logic       cmd_valid;
    logic       cmd_pop;
    frwl_cmd_t  cmd;
    frwl_stat_t stat;
    logic       lock_free;
    logic       shared_rsp;

    // Front end: acceptance and classification.
    frwl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .mode         (mode),
        .requester_id (requester_id),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop),
        .cmd          (cmd)
    );

    // Back end: lock state, waiter queue and results.
    frwl_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_READERS (MAX_READERS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_pop         (cmd_pop),
        .cmd             (cmd),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .status          (status),
        .grantee_id      (grantee_id),
        .grant_is_shared (grant_is_shared),
        .last            (last),
        .stat            (stat)
    );

    // Conditions watched by the checks below.
    assign lock_free  = stat.idle && !stat.held_excl && stat.readers_zero;
    assign shared_rsp = rsp_valid && grant_is_shared;

    // A writer never coexists with readers.
    `FRWL_ASSERT_IMPLIES(a_excl_no_readers, stat.held_excl, stat.readers_zero, "writer with readers")

    // Outside a handoff a free lock never leaves anyone waiting.
    `FRWL_ASSERT_IMPLIES(a_free_no_waiters, lock_free, stat.queue_empty, "free lock with waiters")

    // The shared flag is only set on grants.
    `FRWL_ASSERT_HOLDS(a_shared_on_grant, !shared_rsp || (status == ST_GRANTED), "shared on non-grant")

endmodule
